>>> src/lsf_pkg.sv
package lsf_pkg;

  localparam int LEN_W     = 6;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 64;
  localparam int CNT_W     = 32;
  localparam int Q_DEPTH   = 4;

  localparam logic [7:0] CHAR_NL    = 8'd10;
  localparam logic [7:0] CHAR_UC_A  = 8'd65;
  localparam logic [7:0] CHAR_UC_Z  = 8'd90;
  localparam logic [7:0] CASE_DELTA = 8'd32;

  localparam logic [CFG_IDX_W-1:0] REG_PAT0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT3   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LEN    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ICASE  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NUMBER = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT  = 3'd7;

  localparam logic KIND_VERDICT = 1'b0;
  localparam logic KIND_COUNT   = 1'b1;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_stream;
  } in_item_t;

  typedef struct packed {
    logic             result_kind;
    logic             line_matched;
    logic             show_number;
    logic [CNT_W-1:0] line_number;
    logic [CNT_W-1:0] match_total;
    logic             last_result;
  } out_item_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic upd;
    logic clr;
    logic fold_en;
  } cell_ctrl_t;

  function automatic logic [7:0] fold_byte(input logic [7:0] c, input logic en);
    logic [7:0] r;
    r = c;
    if (en && c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
      r = c + CASE_DELTA;
    end
    return r;
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
    logic [CNT_W-1:0] r;
    r = x;
    if (x != {CNT_W{1'b1}}) begin
      r = x + CNT_W'(1);
    end
    return r;
  endfunction

endpackage

>>> src/lsf_cell.sv
module lsf_cell #(
  parameter int IDX = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  lsf_pkg::cell_ctrl_t     ctrl_i,
  input  logic [7:0]              pat_byte_i,
  input  logic [7:0]              text_i,
  input  logic [lsf_pkg::LEN_W-1:0] used_len_i,
  input  logic                    prev_i,
  output logic                    match_o,
  output logic                    hit_o
);
  import lsf_pkg::*;

  logic match_r;
  logic match_nxt;
  logic active;
  logic is_last;
  logic eq;
  logic bit_new;

  assign active  = LEN_W'(IDX) < used_len_i;
  assign is_last = LEN_W'(IDX) == (used_len_i - LEN_W'(1));
  assign eq      = fold_byte(pat_byte_i, ctrl_i.fold_en) == text_i;
  assign bit_new = prev_i & eq & active;

  always_comb begin
    match_nxt = match_r;
    if (ctrl_i.clr) begin
      match_nxt = 1'b0;
    end else if (ctrl_i.upd) begin
      match_nxt = bit_new;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
    end else begin
      match_r <= match_nxt;
    end
  end

  assign match_o = match_r;
  assign hit_o   = bit_new & is_last;

endmodule

>>> src/lsf_out_queue.sv
module lsf_out_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [1:0]         push_cnt_i,
  input  lsf_pkg::out_item_t item0_i,
  input  lsf_pkg::out_item_t item1_i,
  output logic               room_o,
  output logic               out_valid,
  input  logic               out_ready,
  output lsf_pkg::out_item_t out_data
);
  import lsf_pkg::*;

  localparam int PW = $clog2(Q_DEPTH);
  localparam int CW = $clog2(Q_DEPTH + 1);

  out_item_t       mem_r [Q_DEPTH];
  logic [PW-1:0]   wr_r, wr_nxt;
  logic [PW-1:0]   rd_r, rd_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic            pop;

  assign pop       = out_valid & out_ready;
  assign out_valid = cnt_r != '0;
  assign out_data  = mem_r[rd_r];
  // two free slots guarantee room for the largest request
  assign room_o    = cnt_r <= CW'(Q_DEPTH - 2);

  always_comb begin
    wr_nxt  = wr_r + PW'(push_cnt_i);
    rd_nxt  = rd_r + PW'(pop);
    cnt_nxt = cnt_r + CW'(push_cnt_i) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt_i != 2'd0) begin
      mem_r[wr_r] <= item0_i;
    end
    if (push_cnt_i == 2'd2) begin
      mem_r[wr_r + PW'(1)] <= item1_i;
    end
  end

endmodule

>>> src/line_substring_filter_unit.sv
// Channel  | Handshake              | Payload
// in_      | in_valid / in_ready    | in_data  (text_byte, end_of_stream)
// out_     | out_valid / out_ready  | out_data (kind, matched, numbers, last)
// cfg_     | cfg_valid / cfg_ready  | cfg_index, cfg_data (cfg_ready always 1)
//
// One byte per cycle while in_ready is high: a row of PATTERN_MAX cells updates its partial-match bits
// in the cycle a byte is accepted, and verdicts go into a 4-entry result queue.
// An end-of-stream request can give two results; the queue drains one a cycle while out_ready is high.
// in_ready drops only while the queue has fewer than two free slots.
// Reset (rst_n, synchronous) clears registers, line state, counters and queue.
module line_substring_filter_unit #(
  parameter int PATTERN_MAX = 32,
  parameter int CHUNK_MAX   = 99
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  lsf_pkg::in_item_t                 in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output lsf_pkg::out_item_t                out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [lsf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [lsf_pkg::CFG_W-1:0]         cfg_data
);
  import lsf_pkg::*;

  localparam int BW = $clog2(CHUNK_MAX + 1);

  logic [3:0][CFG_W-1:0] pat_r;
  logic [LEN_W-1:0]      len_r;
  logic                  icase_r;
  logic                  number_r;
  logic                  count_r;

  logic                  lhm_r, lhm_nxt;
  logic [BW-1:0]         bil_r, bil_nxt;
  logic [CNT_W-1:0]      ls_r, ls_nxt;
  logic [CNT_W-1:0]      ml_r, ml_nxt;

  logic [LEN_W-1:0]      used_len;
  logic [7:0]            text_f;
  logic                  accept;
  logic                  is_byte;
  cell_ctrl_t            ctrl;
  logic [PATTERN_MAX:0]  chain;
  logic [PATTERN_MAX-1:0] hits;
  logic                  new_hit;
  logic [BW-1:0]         bil_inc;
  logic                  line_end;
  logic                  hit_line;
  logic                  has_line;
  logic [CNT_W-1:0]      ls_inc, ml_fin;
  logic [1:0]            push_cnt;
  out_item_t             item0, item1;
  logic                  q_room;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r    <= '0;
      len_r    <= '0;
      icase_r  <= 1'b0;
      number_r <= 1'b0;
      count_r  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3: begin
          pat_r[cfg_index[1:0]] <= cfg_data;
        end
        REG_LEN:    len_r    <= cfg_data[LEN_W-1:0];
        REG_ICASE:  icase_r  <= cfg_data[0];
        REG_NUMBER: number_r <= cfg_data[0];
        REG_COUNT:  count_r  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign used_len = (len_r > LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX) : len_r;
  assign text_f   = fold_byte(in_data.text_byte, icase_r);
  assign in_ready = q_room;
  assign accept   = in_valid & in_ready;
  assign is_byte  = ~in_data.end_of_stream;

  assign bil_inc  = bil_r + BW'(1);
  assign line_end = (in_data.text_byte == CHAR_NL) || (bil_inc >= BW'(CHUNK_MAX));
  assign has_line = bil_r != '0;

  always_comb begin
    ctrl.fold_en = icase_r;
    ctrl.upd     = accept & is_byte & (used_len != '0);
    ctrl.clr     = accept & (in_data.end_of_stream | line_end);
  end

  assign chain[0] = 1'b1;

  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    lsf_cell #(.IDX(k)) u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl_i     (ctrl),
      .pat_byte_i (pat_r[k / 8][8 * (k % 8) +: 8]),
      .text_i     (text_f),
      .used_len_i (used_len),
      .prev_i     (chain[k]),
      .match_o    (chain[k+1]),
      .hit_o      (hits[k])
    );
  end

  assign new_hit  = ctrl.upd & (|hits);
  assign hit_line = lhm_r | new_hit | (used_len == '0);
  assign ls_inc   = sat_inc(ls_r);
  assign ml_fin   = hit_line ? sat_inc(ml_r) : ml_r;

  always_comb begin
    lhm_nxt  = lhm_r;
    bil_nxt  = bil_r;
    ls_nxt   = ls_r;
    ml_nxt   = ml_r;
    push_cnt = 2'd0;

    item0.result_kind  = KIND_VERDICT;
    item0.line_matched = hit_line;
    item0.show_number  = number_r;
    item0.line_number  = ls_inc;
    item0.match_total  = ml_fin;
    item0.last_result  = 1'b1;

    item1.result_kind  = KIND_COUNT;
    item1.line_matched = 1'b0;
    item1.show_number  = number_r;
    item1.line_number  = ls_inc;
    item1.match_total  = ml_fin;
    item1.last_result  = 1'b1;

    if (accept) begin
      if (is_byte) begin
        if (line_end) begin
          push_cnt = 2'd1;
          lhm_nxt  = 1'b0;
          bil_nxt  = '0;
          ls_nxt   = ls_inc;
          ml_nxt   = ml_fin;
        end else begin
          lhm_nxt = lhm_r | new_hit;
          bil_nxt = bil_inc;
        end
      end else begin
        // end of stream: close a partial line, then the optional count
        if (has_line) begin
          item0.last_result = ~count_r;
          push_cnt = count_r ? 2'd2 : 2'd1;
        end else if (count_r) begin
          item0 = item1;
          item0.line_number = ls_r;
          item0.match_total = ml_r;
          push_cnt = 2'd1;
        end
        lhm_nxt = 1'b0;
        bil_nxt = '0;
        ls_nxt  = '0;
        ml_nxt  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lhm_r <= 1'b0;
      bil_r <= '0;
      ls_r  <= '0;
      ml_r  <= '0;
    end else begin
      lhm_r <= lhm_nxt;
      bil_r <= bil_nxt;
      ls_r  <= ls_nxt;
      ml_r  <= ml_nxt;
    end
  end

  lsf_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt_i (push_cnt),
    .item0_i    (item0),
    .item1_i    (item1),
    .room_o     (q_room),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule

>>> bench/line_substring_filter_unit_test.sv
`timescale 1ns / 100ps

module line_substring_filter_unit_test;
  import lsf_pkg::*;

  localparam int PAT_MAX      = 32;
  localparam int CHUNK_LIMIT  = 99;
  localparam int RANDOM_ITEMS = 1300;
  localparam int SETTLE       = 8;
  localparam int CYCLE_LIMIT  = 1000000;

  localparam logic [CFG_IDX_W-1:0] PAT_REGS [4] = '{REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3};

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_ready;
  out_item_t            out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;

  line_substring_filter_unit #(
    .PATTERN_MAX(PAT_MAX),
    .CHUNK_MAX  (CHUNK_LIMIT)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // filter model: register copy and per-stream state
  logic [CFG_W-1:0]   pat_word [4];
  logic [LEN_W-1:0]   pat_len_cfg;
  logic               fold_cfg;
  logic               number_cfg;
  logic               count_cfg;
  logic [PAT_MAX-1:0] match_prefixes;
  logic               line_hit;
  logic [6:0]         line_len;
  logic [CNT_W-1:0]   line_count;
  logic [CNT_W-1:0]   hit_count;
  out_item_t          pending_results [$];

  // stimulus side
  logic [7:0] pat_text [PAT_MAX];
  int         needle_len;
  bit         mixed_case;
  bit         quiet;
  int         sent_items;
  int         failures = 0;
  int         cycles = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    if (fold_cfg && c >= CHAR_UC_A && c <= CHAR_UC_Z) begin
      return c + CASE_DELTA;
    end
    return c;
  endfunction

  function automatic int active_len();
    return (pat_len_cfg > PAT_MAX) ? PAT_MAX : int'(pat_len_cfg);
  endfunction

  function automatic logic [7:0] pat_char(input int k);
    return pat_word[k / 8][8 * (k % 8) +: 8];
  endfunction

  function automatic void restart_stream();
    match_prefixes = '0;
    line_hit       = 1'b0;
    line_len       = '0;
    line_count     = '0;
    hit_count      = '0;
  endfunction

  function automatic out_item_t make_result(input logic kind, input logic hit);
    out_item_t r;
    r.result_kind  = kind;
    r.line_matched = hit;
    r.show_number  = number_cfg;
    r.line_number  = line_count;
    r.match_total  = hit_count;
    r.last_result  = 1'b0;
    return r;
  endfunction

  function automatic out_item_t close_line();
    logic hit;
    hit = line_hit || active_len() == 0;
    if (line_count != '1) line_count++;
    if (hit && hit_count != '1) hit_count++;
    match_prefixes = '0;
    line_hit       = 1'b0;
    line_len       = '0;
    return make_result(KIND_VERDICT, hit);
  endfunction

  function automatic void predict_filter(input in_item_t req);
    out_item_t          res [2];
    int                 n;
    int                 m;
    logic [7:0]         c;
    logic [PAT_MAX-1:0] eq;
    n = 0;
    if (!req.end_of_stream) begin
      m = active_len();
      if (m != 0) begin
        c  = to_lower(req.text_byte);
        eq = '0;
        for (int k = 0; k < m; k++) begin
          if (to_lower(pat_char(k)) == c) eq[k] = 1'b1;
        end
        match_prefixes = {match_prefixes[PAT_MAX-2:0], 1'b1} & eq;
        if (match_prefixes[m-1]) line_hit = 1'b1;
      end
      line_len++;
      if (req.text_byte == CHAR_NL || line_len >= CHUNK_LIMIT) begin
        res[0] = close_line();
        n = 1;
      end
    end else begin
      if (line_len != 0) begin
        res[0] = close_line();
        n = 1;
      end
      if (count_cfg) begin
        res[n] = make_result(KIND_COUNT, 1'b0);
        n++;
      end
      restart_stream();
    end
    if (n > 0) res[n-1].last_result = 1'b1;
    for (int i = 0; i < n; i++) pending_results.push_back(res[i]);
  endfunction

  function automatic void check_field(input string name, input logic [CNT_W-1:0] exp_v,
                                      input logic [CNT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      failures++;
    end
  endfunction

  function automatic void check_result(input out_item_t exp_r, input out_item_t act_r);
    check_field("result_kind", CNT_W'(exp_r.result_kind), CNT_W'(act_r.result_kind));
    check_field("line_matched", CNT_W'(exp_r.line_matched), CNT_W'(act_r.line_matched));
    check_field("show_number", CNT_W'(exp_r.show_number), CNT_W'(act_r.show_number));
    check_field("line_number", exp_r.line_number, act_r.line_number);
    check_field("match_total", exp_r.match_total, act_r.match_total);
    check_field("last_result", CNT_W'(exp_r.last_result), CNT_W'(act_r.last_result));
  endfunction

  // config and request prediction come before the result check, so
  // every result finds its expectation already queued
  always @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < 4; w++) pat_word[w] = '0;
      pat_len_cfg = '0;
      fold_cfg    = 1'b0;
      number_cfg  = 1'b0;
      count_cfg   = 1'b0;
      restart_stream();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_PAT0, REG_PAT1, REG_PAT2, REG_PAT3: pat_word[cfg_index[1:0]] = cfg_data;
          REG_LEN:    pat_len_cfg = cfg_data[LEN_W-1:0];
          REG_ICASE:  fold_cfg    = cfg_data[0];
          REG_NUMBER: number_cfg  = cfg_data[0];
          REG_COUNT:  count_cfg   = cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_filter(in_data);
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result with no request pending: %h", out_data);
          failures++;
        end else begin
          check_result(pending_results.pop_front(), out_data);
        end
      end
    end
  end

  function automatic int idle_span();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  initial begin
    int hold;
    out_ready = 1'b0;
    hold = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready = 1'b0;
        hold--;
      end else begin
        out_ready = 1'b1;
        if (!quiet && $urandom_range(0, 99) < 30) begin
          hold = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        end
      end
    end
  end

  task automatic send_item(input logic [7:0] b, input logic eos);
    int gap;
    gap = idle_span();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data.text_byte     = b;
    in_data.end_of_stream = eos;
    in_valid              = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    sent_items++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_eos();
    send_item(8'($urandom_range(0, 255)), 1'b1);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_index = idx;
    cfg_data  = value;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // field value, with junk above the field half of the time
  function automatic logic [CFG_W-1:0] reg_value(input logic [CFG_W-1:0] field, input int width);
    logic [CFG_W-1:0] junk;
    junk = {$urandom, $urandom};
    if ($urandom_range(0, 1)) junk = '0;
    return (junk & ({CFG_W{1'b1}} << width)) | field;
  endfunction

  task automatic load_pattern();
    logic [CFG_W-1:0] word;
    for (int w = 0; w < 4; w++) begin
      for (int b = 0; b < 8; b++) word[8 * b +: 8] = pat_text[8 * w + b];
      write_reg(PAT_REGS[w], word);
    end
  endtask

  // idle point: no request in flight, nothing outstanding
  task automatic settle();
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  function automatic logic [7:0] text_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return "a";
    if (r < 42) return "b";
    if (r < 52) return "A";
    if (r < 60) return "B";
    if (r < 66) return 8'h00;
    if (r < 70) return 8'hFF;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_noise(input int n);
    repeat (n) send_item(text_char(), 1'b0);
  endtask

  // pattern prefix of the given length, letters case-flipped at random
  task automatic send_needle(input int n);
    logic [7:0] b;
    for (int k = 0; k < n; k++) begin
      b = pat_text[k];
      if (((b >= CHAR_UC_A && b <= CHAR_UC_Z) || (b >= "a" && b <= "z")) &&
          $urandom_range(0, 99) < (mixed_case ? 40 : 3)) begin
        b = b ^ CASE_DELTA;
      end
      send_item(b, 1'b0);
    end
  endtask

  task automatic send_line();
    bit lengthy;
    int r;
    lengthy = $urandom_range(0, 99) < 6;
    send_noise($urandom_range(0, lengthy ? 150 : 8));
    r = $urandom_range(0, 99);
    if (r < 60) begin
      send_needle(needle_len);
    end else if (r < 80 && needle_len > 1) begin
      send_needle($urandom_range(1, needle_len - 1));
    end
    send_noise($urandom_range(0, lengthy ? 150 : 8));
    if ($urandom_range(0, 9) != 0) send_text("\n");
  endtask

  task automatic send_stream();
    repeat ($urandom_range(0, 6)) send_line();
    if ($urandom_range(0, 1)) send_noise($urandom_range(1, 6));
    send_eos();
  endtask

  task automatic randomize_filter(input int phase);
    int len;
    settle();
    quiet = (phase % 4 == 3);
    case (phase % 5)
      0: len = 0;
      1: len = 1;
      2: len = PAT_MAX;
      3: len = $urandom_range(PAT_MAX + 1, 63);
      default: len = $urandom_range(2, 12);
    endcase
    for (int k = 0; k < PAT_MAX; k++) begin
      pat_text[k] = (k < len) ? text_char() : 8'($urandom_range(0, 255));
    end
    needle_len = (len > PAT_MAX) ? PAT_MAX : len;
    mixed_case = $urandom_range(0, 1);
    load_pattern();
    write_reg(REG_LEN, reg_value(CFG_W'(len), LEN_W));
    write_reg(REG_ICASE, reg_value(CFG_W'(mixed_case), 1));
    write_reg(REG_NUMBER, reg_value(CFG_W'($urandom_range(0, 1)), 1));
    write_reg(REG_COUNT, reg_value(CFG_W'($urandom_range(0, 1)), 1));
  endtask

  // registers at reset: empty pattern matches everything, no count
  task automatic test_default_config();
    send_text("x\n");
    send_eos();
    send_text("y");
    send_eos();
  endtask

  task automatic test_fold_and_nul();
    settle();
    for (int k = 0; k < PAT_MAX; k++) pat_text[k] = 8'($urandom_range(0, 255));
    pat_text[0] = "A";
    pat_text[1] = "b";
    pat_text[2] = 8'h00;
    pat_text[3] = 8'hFF;
    load_pattern();
    write_reg(REG_LEN, reg_value(CFG_W'(4), LEN_W));
    write_reg(REG_ICASE, reg_value(CFG_W'(1), 1));
    write_reg(REG_NUMBER, reg_value(CFG_W'(1), 1));
    write_reg(REG_COUNT, reg_value(CFG_W'(1), 1));
    send_text("aB");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_text("\n");
    send_text("AB\n");
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_eos();
  endtask

  // length above the cell count is clamped to the full pattern
  task automatic test_oversized_length();
    settle();
    for (int k = 0; k < PAT_MAX; k++) pat_text[k] = "z";
    load_pattern();
    write_reg(REG_LEN, reg_value(CFG_W'({LEN_W{1'b1}}), LEN_W));
    write_reg(REG_ICASE, reg_value(CFG_W'(0), 1));
    write_reg(REG_NUMBER, reg_value(CFG_W'(0), 1));
    send_text("zz\n");
    send_eos();
  endtask

  task automatic test_empty_stream();
    send_eos();
    send_eos();
    settle();
    write_reg(REG_COUNT, reg_value(CFG_W'(0), 1));
    send_eos();
  endtask

  task automatic test_random_streams();
    int phase;
    int goal;
    phase = 0;
    goal  = sent_items + RANDOM_ITEMS;
    while (sent_items < goal) begin
      randomize_filter(phase);
      repeat ($urandom_range(1, 3)) send_stream();
      phase++;
    end
  endtask

  initial begin
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = REG_PAT0;
    cfg_data   = '0;
    quiet      = 1'b0;
    mixed_case = 1'b0;
    needle_len = 0;
    sent_items = 0;
    rst_n      = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_default_config();
    test_fold_and_nul();
    test_oversized_length();
    test_empty_stream();
    test_random_streams();
    settle();

    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
